// ===== sv/opsv_pkg.sv =====
// shared command and status codes for the operand stack core
package opsv_pkg;

	typedef enum logic [3:0] {
		CMD_PUSH     = 4'd0,
		CMD_POP      = 4'd1,
		CMD_DUP      = 4'd2,
		CMD_SWAP     = 4'd3,
		CMD_CLEAR    = 4'd4,
		CMD_READVAR  = 4'd5,
		CMD_WRITEVAR = 4'd6,
		CMD_SETLAST  = 4'd7,
		CMD_GETLAST  = 4'd8,
		CMD_FINISH   = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_FEW     = 2'd2,
		ST_BADNAME = 2'd3
	} status_t;

	localparam int unsigned VAR_COUNT = 26;
	localparam int unsigned VAR_AW    = 5;
	localparam logic [7:0]  LETTER_A  = 8'h61;
	localparam logic [7:0]  LETTER_Z  = 8'h7a;
	localparam int unsigned WORD_W    = 64;

endpackage

// ===== sv/operand_stack_with_variables_core.sv =====
// operand stack with duplicate and swap, variable store and last-result register
//
// A request is taken at a rising edge where start is high and busy is low;
// command, data_word and letter_code are sampled there. Every request gives
// exactly one result: done is high for one cycle with read_word, status and
// fill_level valid in that same cycle. The receiver cannot stall, so a
// result is never held back.
// done is registered from S_EXEC for every command except a swap of two
// entries, which goes on through S_SWAP2 before done. busy is high
// from the request edge until the edge that raises done, so a new request
// can be taken in the cycle where the previous result is shown. S_SWAP2
// is there because the stack memory has a single write port, which a swap
// uses twice; reads from the stack memory are registered.
// The stack lives in a synchronous memory with two read ports; both top
// entries are read in the request cycle, and a swap writes them back after.
// The variable store is a 26-entry memory whose per-entry valid bits are
// cleared by reset, so a variable never written reads as zero.
// Reset empties the stack, selects variable a and zeroes the last result;
// the block is ready as soon as reset is released.
module operand_stack_with_variables_core
	import opsv_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [3:0]          command,
	input  logic [WORD_W-1:0]   data_word,
	input  logic [7:0]          letter_code,
	output logic                done,
	output logic [WORD_W-1:0]   read_word,
	output logic [1:0]          status,
	output logic [7:0]          fill_level
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
	localparam logic [LW-1:0] LVL_MAX = LW'(STACK_DEPTH);
	localparam logic [LW-1:0] LVL_ONE = LW'(1);
	localparam logic [LW-1:0] LVL_TWO = LW'(2);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SWAP2
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [WORD_W-1:0]   data_q;
	logic [LW-1:0]       level_q;
	logic [VAR_AW-1:0]   sel_q;
	logic [WORD_W-1:0]   last_q;
	logic                done_q;
	logic [WORD_W-1:0]   read_word_q;
	status_t             status_q;
	logic [7:0]          fill_level_q;

	// stack memory, two read ports, one write port
	logic [WORD_W-1:0]   stk_mem [STACK_DEPTH];
	logic [WORD_W-1:0]   top_s1;
	logic [WORD_W-1:0]   sec_s1;
	logic                stk_we;
	logic [AW-1:0]       stk_waddr;
	logic [WORD_W-1:0]   stk_wdata;

	// variable store with valid bits
	logic [WORD_W-1:0]   var_mem [VAR_COUNT];
	logic [VAR_COUNT-1:0] var_vld_q;
	logic [WORD_W-1:0]   var_rdata_s1;
	logic                var_vld_s1;
	logic                name_ok_s1;
	logic [VAR_AW-1:0]   name_idx_s1;
	logic                var_we;

	logic                accept;
	logic [LW-1:0]       lvl_m1;
	logic [LW-1:0]       lvl_m2;
	logic [AW-1:0]       top_addr;
	logic [AW-1:0]       sec_addr;
	logic                name_ok;
	logic [VAR_AW-1:0]   name_idx;
	logic [7:0]          name_diff;

	logic [LW-1:0]       nxt_level;
	logic [WORD_W-1:0]   res_word;
	status_t             res_status;
	logic [WORD_W-1:0]   pop_word;
	logic                swap_go;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign lvl_m1    = level_q - LVL_ONE;
	assign lvl_m2    = level_q - LVL_TWO;
	assign top_addr  = lvl_m1[AW-1:0];
	assign sec_addr  = lvl_m2[AW-1:0];
	assign name_ok   = (letter_code >= LETTER_A) && (letter_code <= LETTER_Z);
	assign name_diff = letter_code - LETTER_A;
	assign name_idx  = name_diff[VAR_AW-1:0];
	assign pop_word  = (level_q != '0) ? top_s1 : '0;
	assign swap_go   = (cmd_q == CMD_SWAP) && (level_q >= LVL_TWO);

	always_comb begin
		nxt_level  = level_q;
		res_word   = '0;
		res_status = ST_OK;
		stk_we     = 1'b0;
		stk_waddr  = level_q[AW-1:0];
		stk_wdata  = data_q;
		var_we     = 1'b0;
		if (state_q == S_EXEC) begin
			case (cmd_q)
				CMD_PUSH: begin
					if (level_q < LVL_MAX) begin
						stk_we    = 1'b1;
						nxt_level = level_q + LVL_ONE;
					end else begin
						res_status = ST_FULL;
					end
				end
				CMD_POP: begin
					res_word = pop_word;
					if (level_q != '0) begin
						nxt_level = lvl_m1;
					end
				end
				CMD_DUP: begin
					if (level_q == '0) begin
						res_status = ST_FEW;
					end else if (level_q >= LVL_MAX) begin
						res_status = ST_FULL;
					end else begin
						stk_we    = 1'b1;
						stk_wdata = top_s1;
						nxt_level = level_q + LVL_ONE;
					end
				end
				CMD_SWAP: begin
					if (level_q < LVL_TWO) begin
						res_status = ST_FEW;
					end else begin
						stk_we    = 1'b1;
						stk_waddr = top_addr;
						stk_wdata = sec_s1;
					end
				end
				CMD_CLEAR: begin
					nxt_level = '0;
				end
				CMD_READVAR: begin
					if (name_ok_s1) begin
						res_word = var_vld_s1 ? var_rdata_s1 : '0;
					end else begin
						res_status = ST_BADNAME;
					end
				end
				CMD_WRITEVAR: begin
					var_we = 1'b1;
				end
				CMD_GETLAST: begin
					res_word = last_q;
				end
				CMD_FINISH: begin
					res_word  = pop_word;
					nxt_level = '0;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_SWAP2) begin
			// second half of swap: old top goes below
			stk_we    = 1'b1;
			stk_waddr = sec_addr;
			stk_wdata = top_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			top_s1 <= stk_mem[top_addr];
			sec_s1 <= stk_mem[sec_addr];
		end
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			var_rdata_s1 <= var_mem[name_idx];
		end
		if (var_we) begin
			var_mem[sel_q] <= data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_vld_q   <= '0;
			var_vld_s1  <= 1'b0;
			name_ok_s1  <= 1'b0;
			name_idx_s1 <= '0;
		end else begin
			if (accept) begin
				var_vld_s1  <= name_ok && var_vld_q[name_idx];
				name_ok_s1  <= name_ok;
				name_idx_s1 <= name_idx;
			end
			if (var_we) begin
				var_vld_q[sel_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= CMD_PUSH;
			data_q       <= '0;
			level_q      <= '0;
			sel_q        <= '0;
			last_q       <= '0;
			done_q       <= 1'b0;
			read_word_q  <= '0;
			status_q     <= ST_OK;
			fill_level_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd_t'(command);
						data_q  <= data_word;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd_q == CMD_SETLAST) begin
						last_q <= data_q;
					end else if (cmd_q == CMD_FINISH) begin
						last_q <= pop_word;
					end
					if (cmd_q == CMD_READVAR && name_ok_s1) begin
						sel_q <= name_idx_s1;
					end
					level_q <= nxt_level;
					if (swap_go) begin
						state_q <= S_SWAP2;
					end else begin
						done_q       <= 1'b1;
						read_word_q  <= res_word;
						status_q     <= res_status;
						fill_level_q <= 8'(nxt_level);
						state_q      <= S_IDLE;
					end
				end
				S_SWAP2: begin
					done_q       <= 1'b1;
					read_word_q  <= '0;
					status_q     <= ST_OK;
					fill_level_q <= 8'(level_q);
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign read_word  = read_word_q;
	assign status     = status_q;
	assign fill_level = fill_level_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_MAX)
		else $error("stack level above depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("request not followed by busy");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_EXEC || state_q == S_SWAP2) && state_q == S_IDLE)
		else $error("result strobe without a finished request");

	a_fill_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fill_level == 8'(level_q))
		else $error("reported fill level differs from stack level");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |-> busy && (stk_waddr < AW'(STACK_DEPTH - 1) || stk_waddr == AW'(STACK_DEPTH - 1)))
		else $error("stack write outside a request");

endmodule
